// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define TTCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define TTCP_ASSERT_CR(lbl, prop, msg) `TTCP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/ttcp_pkg.sv =====
package ttcp_pkg;

  // Screen geometry defaults
  localparam int unsigned ROW_COUNT_DEF = 30;
  localparam int unsigned COL_COUNT     = 80;

  localparam logic [2:0] COLOR_WHITE = 3'd7;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LEFT  = 8'h1C;
  localparam logic [7:0] CH_RIGHT = 8'h1D;
  localparam logic [7:0] CH_DOWN  = 8'h1E;
  localparam logic [7:0] CH_UP    = 8'h1F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Drawing operations
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_DRAW      = 4'd1,
    OP_BLANK     = 4'd2,
    OP_CLR_ROW   = 4'd3,
    OP_CLR_SCR   = 4'd4,
    OP_RESET_SCR = 4'd5,
    OP_SCROLL    = 4'd6,
    OP_ROW_COLOR = 4'd7,
    OP_ALL_COLOR = 4'd8,
    OP_BLINK     = 4'd9
  } op_e;

  // Armed two-byte color command
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_LINE   = 2'd1,
    PEND_SCREEN = 2'd2
  } pend_e;

  // Action on the row color store
  typedef enum logic [1:0] {
    CA_NONE   = 2'd0,
    CA_WRITE  = 2'd1,
    CA_FILL   = 2'd2,
    CA_SCROLL = 2'd3
  } color_act_e;

  typedef struct packed {
    logic [4:0] cur_row;
    logic [6:0] cur_col;
    logic [4:0] saved_row;
    logic [6:0] saved_col;
    pend_e      pend;
    logic       blink;
  } cursor_t;

  typedef struct packed {
    color_act_e act;
    logic [4:0] row;
    logic [2:0] color;
  } color_cmd_t;

  typedef struct packed {
    op_e        op;
    logic [4:0] row;
    logic [6:0] col;
    logic [6:0] glyph;
    logic [2:0] color;
    logic       blink_on;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       last;
  } result_t;

  // Keep the high bit of each 2-bit channel of rr_gg_bb
  function automatic logic [2:0] reduce_color(input logic [5:0] c);
    return {c[5], c[3], c[1]};
  endfunction

endpackage

// ===== rtl/text_terminal_command_parser_top.sv =====
// Channel | Direction | Beat
// in      | input     | in_byte_i (one character or command byte)
// out     | output    | op_o row_o col_o glyph_o color_o blink_on_o cursor_row_o
//         |           | cursor_col_o last_o (one drawing operation)
//
// A byte sits in the input register, then its results load the output register.
// One byte per cycle sustained when it yields one beat and the output does not stall;
// a printable byte that wraps holds back the next byte, its second beat held in a spare
// slot behind the output register.
// Reset puts the cursor at top left, clears blink and any armed color command and sets
// every row color to white; no clearing pass is needed.
// A stalled output holds at most one byte in the input register.
module text_terminal_command_parser_top #(
  parameter int unsigned ROW_COUNT = ttcp_pkg::ROW_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] op_o,
  output logic [4:0] row_o,
  output logic [6:0] col_o,
  output logic [6:0] glyph_o,
  output logic [2:0] color_o,
  output logic       blink_on_o,
  output logic [4:0] cursor_row_o,
  output logic [6:0] cursor_col_o,
  output logic       last_o
);

  logic                 in_v_q;
  logic [7:0]           in_byte_q;
  logic                 fire;
  logic                 free;
  ttcp_pkg::cursor_t    cur_q;
  ttcp_pkg::cursor_t    cur_d;
  ttcp_pkg::color_cmd_t cmd;
  ttcp_pkg::result_t    res0;
  ttcp_pkg::result_t    res1;
  ttcp_pkg::result_t    out_beat;
  logic                 two;
  logic [2:0]           row_color;

  assign fire       = in_v_q && free;
  assign in_ready_o = !in_v_q || fire;

  // Capture the input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= in_byte_i;
  end

  // Hold cursor, saved cursor, blink and armed color command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '{cur_row: '0, cur_col: '0, saved_row: '0, saved_col: '0,
                 pend: ttcp_pkg::PEND_NONE, blink: 1'b0};
    end else if (fire) begin
      cur_q <= cur_d;
    end
  end

  ttcp_colors #(.ROW_COUNT(ROW_COUNT)) u_colors (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .cmd_i      (cmd),
    .rd_row_i   (cur_q.cur_row),
    .rd_color_o (row_color)
  );

  ttcp_decode #(.ROW_COUNT(ROW_COUNT)) u_decode (
    .byte_i      (in_byte_q),
    .cur_i       (cur_q),
    .row_color_i (row_color),
    .nxt_o       (cur_d),
    .cmd_o       (cmd),
    .res0_o      (res0),
    .res1_o      (res1),
    .two_o       (two)
  );

  ttcp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .two_i       (two),
    .res0_i      (res0),
    .res1_i      (res1),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_beat),
    .free_o      (free)
  );

  assign op_o         = out_beat.op;
  assign row_o        = out_beat.row;
  assign col_o        = out_beat.col;
  assign glyph_o      = out_beat.glyph;
  assign color_o      = out_beat.color;
  assign blink_on_o   = out_beat.blink_on;
  assign cursor_row_o = out_beat.cursor_row;
  assign cursor_col_o = out_beat.cursor_col;
  assign last_o       = out_beat.last;

endmodule

// ===== rtl/ttcp_colors.sv =====
module ttcp_colors #(
  parameter int unsigned ROW_COUNT = ttcp_pkg::ROW_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ttcp_pkg::color_cmd_t  cmd_i,
  input  logic [4:0]            rd_row_i,
  output logic [2:0]            rd_color_o
);

  localparam int unsigned IdxW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [5:0]  RowCnt = 6'(ROW_COUNT);

  logic [2:0]      color_q [ROW_COUNT];
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;
  logic            wr_in_range;
  logic            rd_in_range;

  assign wr_idx      = cmd_i.row[IdxW-1:0];
  assign rd_idx      = rd_row_i[IdxW-1:0];
  assign wr_in_range = {1'b0, cmd_i.row} < RowCnt;
  assign rd_in_range = {1'b0, rd_row_i} < RowCnt;

  // Read the color of the cursor row
  assign rd_color_o = rd_in_range ? color_q[rd_idx] : ttcp_pkg::COLOR_WHITE;

  // Write one row, fill all rows or shift all rows up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(ROW_COUNT); i++) color_q[i] <= ttcp_pkg::COLOR_WHITE;
    end else if (en_i) begin
      unique case (cmd_i.act)
        ttcp_pkg::CA_WRITE: begin
          if (wr_in_range) color_q[wr_idx] <= cmd_i.color;
        end
        ttcp_pkg::CA_FILL: begin
          for (int i = 0; i < int'(ROW_COUNT); i++) color_q[i] <= cmd_i.color;
        end
        ttcp_pkg::CA_SCROLL: begin
          for (int i = 0; i + 1 < int'(ROW_COUNT); i++) color_q[i] <= color_q[i+1];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ttcp_decode.sv =====
module ttcp_decode #(
  parameter int unsigned ROW_COUNT = ttcp_pkg::ROW_COUNT_DEF
) (
  input  logic [7:0]           byte_i,
  input  ttcp_pkg::cursor_t    cur_i,
  input  logic [2:0]           row_color_i,
  output ttcp_pkg::cursor_t    nxt_o,
  output ttcp_pkg::color_cmd_t cmd_o,
  output ttcp_pkg::result_t    res0_o,
  output ttcp_pkg::result_t    res1_o,
  output logic                 two_o
);

  localparam logic [4:0] RowLast  = 5'(ROW_COUNT - 1);
  localparam logic [5:0] RowCnt   = 6'(ROW_COUNT);
  localparam logic [6:0] ColLast  = 7'(ttcp_pkg::COL_COUNT - 1);
  localparam logic [6:0] ColTab   = 7'(ttcp_pkg::COL_COUNT - 5);
  localparam logic [7:0] ColCnt8  = 8'(ttcp_pkg::COL_COUNT);

  // Line down: copy color to the next row, or scroll on the bottom row
  ttcp_pkg::op_e        ld_op;
  logic [4:0]           ld_row;
  logic [2:0]           ld_color;
  logic [4:0]           ld_cur_row;
  ttcp_pkg::color_cmd_t ld_cmd;

  always_comb begin
    if (cur_i.cur_row < RowLast) begin
      ld_op      = ttcp_pkg::OP_ROW_COLOR;
      ld_row     = cur_i.cur_row + 5'd1;
      ld_color   = row_color_i;
      ld_cur_row = cur_i.cur_row + 5'd1;
      ld_cmd     = '{act: ttcp_pkg::CA_WRITE, row: cur_i.cur_row + 5'd1, color: row_color_i};
    end else begin
      ld_op      = ttcp_pkg::OP_SCROLL;
      ld_row     = '0;
      ld_color   = '0;
      ld_cur_row = cur_i.cur_row;
      ld_cmd     = '{act: ttcp_pkg::CA_SCROLL, row: '0, color: '0};
    end
  end

  ttcp_pkg::op_e nx_op;
  logic [4:0]    nx_row;
  logic [6:0]    nx_col;
  logic [6:0]    nx_glyph;
  logic [2:0]    nx_color;
  logic [2:0]    pc;
  logic [6:0]    tab_base;
  logic [7:0]    col_inc;

  assign pc       = ttcp_pkg::reduce_color(byte_i[5:0]);
  assign tab_base = {cur_i.cur_col[6:2], 2'b00};
  assign col_inc  = {1'b0, cur_i.cur_col} + 8'd1;

  // Decode one byte against the current cursor state
  always_comb begin
    nxt_o    = cur_i;
    cmd_o    = '{act: ttcp_pkg::CA_NONE, row: '0, color: '0};
    nx_op    = ttcp_pkg::OP_NONE;
    nx_row   = '0;
    nx_col   = '0;
    nx_glyph = '0;
    nx_color = '0;
    two_o    = 1'b0;

    if (cur_i.pend != ttcp_pkg::PEND_NONE) begin
      // Second byte of a color command
      nxt_o.pend = ttcp_pkg::PEND_NONE;
      unique case (cur_i.pend)
        ttcp_pkg::PEND_LINE: begin
          cmd_o    = '{act: ttcp_pkg::CA_WRITE, row: cur_i.cur_row, color: pc};
          nx_op    = ttcp_pkg::OP_ROW_COLOR;
          nx_row   = cur_i.cur_row;
          nx_color = pc;
        end
        ttcp_pkg::PEND_SCREEN: begin
          cmd_o    = '{act: ttcp_pkg::CA_FILL, row: '0, color: pc};
          nx_op    = ttcp_pkg::OP_ALL_COLOR;
          nx_color = pc;
        end
        default: ;
      endcase
    end else if (byte_i[7]) begin
      // Command byte, bit 4 ignored outside the row and column commands
      priority if (byte_i[6]) begin
        if ({1'b0, byte_i[5:0]} < ColCnt8[6:0]) nxt_o.cur_col = {1'b0, byte_i[5:0]};
      end else if (byte_i[5]) begin
        if ({1'b0, byte_i[4:0]} < RowCnt) nxt_o.cur_row = byte_i[4:0];
      end else if (byte_i[3]) begin
        nxt_o.pend = byte_i[0] ? ttcp_pkg::PEND_LINE : ttcp_pkg::PEND_SCREEN;
      end else if (byte_i[2]) begin
        priority if (byte_i[1]) begin
          if (byte_i[0]) begin
            nx_op  = ttcp_pkg::OP_CLR_ROW;
            nx_row = cur_i.cur_row;
          end else begin
            nx_op  = ttcp_pkg::OP_CLR_SCR;
          end
        end else if (byte_i[0]) begin
          nxt_o.cur_row = cur_i.saved_row;
          nxt_o.cur_col = cur_i.saved_col;
        end else begin
          nxt_o.saved_row = cur_i.cur_row;
          nxt_o.saved_col = cur_i.cur_col;
        end
      end else if (byte_i[1]) begin
        nxt_o.blink = byte_i[0];
        nx_op       = ttcp_pkg::OP_BLINK;
      end else if (byte_i[0]) begin
        nxt_o.cur_row = '0;
        nxt_o.cur_col = '0;
        cmd_o         = '{act: ttcp_pkg::CA_FILL, row: '0, color: ttcp_pkg::COLOR_WHITE};
        nx_op         = ttcp_pkg::OP_RESET_SCR;
      end else begin
        nx_op = ttcp_pkg::OP_NONE;
      end
    end else begin
      // Control or printable character
      unique case (byte_i)
        ttcp_pkg::CH_BS: begin
          if (cur_i.cur_col != 7'd0) begin
            nxt_o.cur_col = cur_i.cur_col - 7'd1;
            nx_op         = ttcp_pkg::OP_BLANK;
            nx_row        = cur_i.cur_row;
            nx_col        = cur_i.cur_col - 7'd1;
          end
        end
        ttcp_pkg::CH_DEL: begin
          nx_op  = ttcp_pkg::OP_BLANK;
          nx_row = cur_i.cur_row;
          nx_col = cur_i.cur_col;
          if (cur_i.cur_col < ColLast) nxt_o.cur_col = cur_i.cur_col + 7'd1;
        end
        ttcp_pkg::CH_TAB: begin
          nxt_o.cur_col = (tab_base < ColTab) ? tab_base + 7'd4 : ColLast;
        end
        ttcp_pkg::CH_LF, ttcp_pkg::CH_VT: begin
          if (byte_i == ttcp_pkg::CH_LF) nxt_o.cur_col = '0;
          nxt_o.cur_row = ld_cur_row;
          cmd_o         = ld_cmd;
          nx_op         = ld_op;
          nx_row        = ld_row;
          nx_color      = ld_color;
        end
        ttcp_pkg::CH_FF: begin
          nxt_o.cur_row = RowLast;
          nxt_o.cur_col = '0;
          cmd_o         = '{act: ttcp_pkg::CA_FILL, row: '0, color: ttcp_pkg::COLOR_WHITE};
          nx_op         = ttcp_pkg::OP_RESET_SCR;
        end
        ttcp_pkg::CH_CR: nxt_o.cur_col = '0;
        ttcp_pkg::CH_LEFT: begin
          if (cur_i.cur_col != 7'd0) nxt_o.cur_col = cur_i.cur_col - 7'd1;
        end
        ttcp_pkg::CH_RIGHT: begin
          if (cur_i.cur_col < ColLast) nxt_o.cur_col = cur_i.cur_col + 7'd1;
        end
        ttcp_pkg::CH_DOWN: begin
          if (cur_i.cur_row < RowLast) nxt_o.cur_row = cur_i.cur_row + 5'd1;
        end
        ttcp_pkg::CH_UP: begin
          if (cur_i.cur_row != 5'd0) nxt_o.cur_row = cur_i.cur_row - 5'd1;
        end
        default: begin
          if (byte_i >= ttcp_pkg::CH_SPACE) begin
            // Draw, advance, wrap to the next line past the last column
            nx_op    = ttcp_pkg::OP_DRAW;
            nx_row   = cur_i.cur_row;
            nx_col   = cur_i.cur_col;
            nx_glyph = byte_i[6:0];
            if (col_inc >= ColCnt8) begin
              nxt_o.cur_col = '0;
              nxt_o.cur_row = ld_cur_row;
              cmd_o         = ld_cmd;
              two_o         = 1'b1;
            end else begin
              nxt_o.cur_col = col_inc[6:0];
            end
          end
        end
      endcase
    end
  end

  // Tag both beats with the cursor and blink state after this byte
  assign res0_o = '{op: nx_op, row: nx_row, col: nx_col, glyph: nx_glyph, color: nx_color,
                    blink_on: nxt_o.blink, cursor_row: nxt_o.cur_row,
                    cursor_col: nxt_o.cur_col, last: !two_o};
  assign res1_o = '{op: ld_op, row: ld_row, col: '0, glyph: '0, color: ld_color,
                    blink_on: nxt_o.blink, cursor_row: nxt_o.cur_row,
                    cursor_col: nxt_o.cur_col, last: 1'b1};

endmodule

// ===== rtl/ttcp_outbuf.sv =====
module ttcp_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              two_i,
  input  ttcp_pkg::result_t res0_i,
  input  ttcp_pkg::result_t res1_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output ttcp_pkg::result_t out_o,
  output logic              free_o
);

  logic              out_v_q;
  logic              ext_v_q;
  ttcp_pkg::result_t out_q;
  ttcp_pkg::result_t ext_q;

  // Room for a new byte: no second beat waiting and the head slot empty or its beat leaving
  assign free_o      = !ext_v_q && (!out_v_q || out_ready_i);
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Track which slots hold a beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      ext_v_q <= 1'b0;
    end else if (ext_v_q) begin
      if (out_ready_i) ext_v_q <= 1'b0;
    end else if (push_i) begin
      out_v_q <= 1'b1;
      ext_v_q <= two_i;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  // Load the payload slots
  always_ff @(posedge clk_i) begin
    if (ext_v_q) begin
      if (out_ready_i) out_q <= ext_q;
    end else if (push_i) begin
      out_q <= res0_i;
      ext_q <= res1_i;
    end
  end

endmodule

// ===== rtl/ttcp_checker.sv =====
`include "assert_macros.svh"

module ttcp_checker #(
  parameter int unsigned ROW_COUNT = ttcp_pkg::ROW_COUNT_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] op_i,
  input logic [4:0] cursor_row_i,
  input logic [6:0] cursor_col_i,
  input logic       last_i
);

  localparam logic [5:0] RowCnt = 6'(ROW_COUNT);
  localparam logic [7:0] ColCnt = 8'(ttcp_pkg::COL_COUNT);
  localparam logic [3:0] OpMax  = ttcp_pkg::OP_BLINK;

  // Stalled beat holds
  property p_out_hold;
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(op_i) && $stable(last_i) &&
      $stable(cursor_col_i);
  endproperty
  `TTCP_ASSERT_CR(a_out_hold, p_out_hold, "output beat changed while stalled")

  // Only defined operations leave the block
  `TTCP_ASSERT_CR(a_op_range, out_valid_i |-> op_i <= OpMax, "undefined operation code")

  // Cursor stays on screen
  property p_cursor_on_screen;
    out_valid_i |-> cursor_row_i < RowCnt && cursor_col_i < ColCnt;
  endproperty
  `TTCP_ASSERT_CR(a_cursor_on_screen, p_cursor_on_screen, "cursor off screen")

  // Second beat of a wrapping byte follows with no gap
  property p_second_beat;
    out_valid_i && out_ready_i && !last_i |=> out_valid_i;
  endproperty
  `TTCP_ASSERT_CR(a_second_beat, p_second_beat, "gap inside a two-beat byte")

endmodule

bind text_terminal_command_parser_top ttcp_checker #(.ROW_COUNT(ROW_COUNT)) u_ttcp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .op_i         (op_o),
  .cursor_row_i (cursor_row_o),
  .cursor_col_i (cursor_col_o),
  .last_i       (last_o)
);

// ===== dv/ttcp_draw_checker.sv =====
module ttcp_draw_checker
  import ttcp_pkg::*;
#(
  parameter int unsigned ROW_COUNT = ROW_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  op_i,
  input  logic [4:0]  row_i,
  input  logic [6:0]  col_i,
  input  logic [6:0]  glyph_i,
  input  logic [2:0]  color_i,
  input  logic        blink_on_i,
  input  logic [4:0]  cursor_row_i,
  input  logic [6:0]  cursor_col_i,
  input  logic        last_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Terminal state tracked alongside the block
  logic [4:0] cur_row;
  logic [6:0] cur_col;
  logic [4:0] saved_row;
  logic [6:0] saved_col;
  pend_e      pend;
  logic       blink;
  logic [2:0] row_color [32];

  // Drawing ops of the current byte, then all ops still owed by the block
  result_t    byte_ops [$];
  result_t    draw_q [$];

  function automatic result_t make_op(op_e op, logic [4:0] row, logic [6:0] col,
                                      logic [6:0] glyph, logic [2:0] color);
    result_t r;
    r       = '0;
    r.op    = op;
    r.row   = row;
    r.col   = col;
    r.glyph = glyph;
    r.color = color;
    return r;
  endfunction

  // Step down one row carrying the row color, or scroll on the bottom row
  task automatic line_down();
    logic [2:0] hue;
    if (cur_row < ROW_COUNT - 1) begin
      hue = row_color[cur_row];
      row_color[cur_row + 5'd1] = hue;
      cur_row++;
      byte_ops.push_back(make_op(OP_ROW_COLOR, cur_row, 7'd0, 7'd0, hue));
    end else begin
      for (int i = 0; i + 1 < ROW_COUNT; i++) row_color[i] = row_color[i + 1];
      byte_ops.push_back(make_op(OP_SCROLL, 5'd0, 7'd0, 7'd0, 3'd0));
    end
  endtask

  // Work out the drawing ops one byte causes and queue them
  task automatic predict_byte(input logic [7:0] b);
    logic [2:0] hue;
    op_e        cmd_op;
    byte_ops.delete();
    if (pend != PEND_NONE) begin
      // Second byte of a color command: keep the high bit of each channel
      hue = {b[5], b[3], b[1]};
      if (pend == PEND_LINE) begin
        row_color[cur_row] = hue;
        byte_ops.push_back(make_op(OP_ROW_COLOR, cur_row, 7'd0, 7'd0, hue));
      end else if (pend == PEND_SCREEN) begin
        for (int i = 0; i < ROW_COUNT; i++) row_color[i] = hue;
        byte_ops.push_back(make_op(OP_ALL_COLOR, 5'd0, 7'd0, 7'd0, hue));
      end else begin
        byte_ops.push_back(make_op(OP_NONE, 5'd0, 7'd0, 7'd0, 3'd0));
      end
      pend = PEND_NONE;
    end else if (b[7]) begin
      // Command byte, bit 4 ignored outside the row and column commands
      cmd_op = OP_NONE;
      if (b[6]) begin
        if (b[5:0] < COL_COUNT) cur_col = {1'b0, b[5:0]};
      end else if (b[5]) begin
        if (b[4:0] < ROW_COUNT) cur_row = b[4:0];
      end else if (b[3]) begin
        pend = b[0] ? PEND_LINE : PEND_SCREEN;
      end else if (b[2]) begin
        if (b[1]) begin
          cmd_op = b[0] ? OP_CLR_ROW : OP_CLR_SCR;
        end else if (b[0]) begin
          cur_row = saved_row;
          cur_col = saved_col;
        end else begin
          saved_row = cur_row;
          saved_col = cur_col;
        end
      end else if (b[1]) begin
        blink  = b[0];
        cmd_op = OP_BLINK;
      end else if (b[0]) begin
        cur_row = '0;
        cur_col = '0;
        foreach (row_color[i]) row_color[i] = COLOR_WHITE;
        cmd_op = OP_RESET_SCR;
      end
      byte_ops.push_back(make_op(cmd_op, (cmd_op == OP_CLR_ROW) ? cur_row : 5'd0,
                                 7'd0, 7'd0, 3'd0));
    end else begin
      // Control or printable character
      case (b)
        CH_BS: begin
          if (cur_col != 0) begin
            cur_col--;
            byte_ops.push_back(make_op(OP_BLANK, cur_row, cur_col, 7'd0, 3'd0));
          end
        end
        CH_DEL: begin
          byte_ops.push_back(make_op(OP_BLANK, cur_row, cur_col, 7'd0, 3'd0));
          if (cur_col < COL_COUNT - 1) cur_col++;
        end
        CH_TAB: begin
          cur_col = cur_col & 7'h7C;
          if (cur_col < COL_COUNT - 5) cur_col += 7'd4;
          else cur_col = 7'(COL_COUNT - 1);
        end
        CH_LF: begin
          cur_col = '0;
          line_down();
        end
        CH_VT: line_down();
        CH_FF: begin
          cur_row = 5'(ROW_COUNT - 1);
          cur_col = '0;
          foreach (row_color[i]) row_color[i] = COLOR_WHITE;
          byte_ops.push_back(make_op(OP_RESET_SCR, 5'd0, 7'd0, 7'd0, 3'd0));
        end
        CH_CR: cur_col = '0;
        CH_LEFT: begin
          if (cur_col != 0) cur_col--;
        end
        CH_RIGHT: begin
          if (cur_col < COL_COUNT - 1) cur_col++;
        end
        CH_DOWN: begin
          if (cur_row < ROW_COUNT - 1) cur_row++;
        end
        CH_UP: begin
          if (cur_row != 0) cur_row--;
        end
        default: begin
          if (b >= CH_SPACE) begin
            byte_ops.push_back(make_op(OP_DRAW, cur_row, cur_col, b[6:0], 3'd0));
            cur_col++;
            // Wrap past the last column
            if (cur_col >= COL_COUNT) begin
              cur_col = '0;
              line_down();
            end
          end
        end
      endcase
      if (byte_ops.size() == 0) byte_ops.push_back(make_op(OP_NONE, 5'd0, 7'd0, 7'd0, 3'd0));
    end

    // Stamp the state after this byte and mark the final op
    foreach (byte_ops[i]) begin
      byte_ops[i].blink_on   = blink;
      byte_ops[i].cursor_row = cur_row;
      byte_ops[i].cursor_col = cur_col;
      byte_ops[i].last       = (i == byte_ops.size() - 1);
      draw_q.push_back(byte_ops[i]);
    end
  endtask

  function automatic bit field_bad(string name, int unsigned want, int unsigned got);
    if (want == got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    return 1'b1;
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    bit      bad;
    if (!rst_ni) begin
      cur_row   = '0;
      cur_col   = '0;
      saved_row = '0;
      saved_col = '0;
      pend      = PEND_NONE;
      blink     = 1'b0;
      foreach (row_color[i]) row_color[i] = COLOR_WHITE;
      draw_q.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_byte(in_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (draw_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: unexpected beat, expected none, got op %0d row %0d col %0d",
                   $realtime, op_i, row_i, col_i);
        end else begin
          want = draw_q.pop_front();
          bad  = 1'b0;
          bad |= field_bad("op", want.op, op_i);
          bad |= field_bad("row", want.row, row_i);
          bad |= field_bad("col", want.col, col_i);
          bad |= field_bad("glyph", want.glyph, glyph_i);
          bad |= field_bad("color", want.color, color_i);
          bad |= field_bad("blink_on", want.blink_on, blink_on_i);
          bad |= field_bad("cursor_row", want.cursor_row, cursor_row_i);
          bad |= field_bad("cursor_col", want.cursor_col, cursor_col_i);
          bad |= field_bad("last", want.last, last_i);
          if (bad) mismatch_cnt_o++;
        end
      end
    end
    pending_cnt_o = draw_q.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb
  import ttcp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_COUNT   = ROW_COUNT_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 130;

  // Bytes with no effect
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ESC = 8'h1B;

  // Command bytes
  localparam logic [7:0] CMD_RESET      = 8'h81;
  localparam logic [7:0] CMD_BLINK_ON   = 8'h83;
  localparam logic [7:0] CMD_SAVE       = 8'h84;
  localparam logic [7:0] CMD_RESTORE    = 8'h85;
  localparam logic [7:0] CMD_CLR_SCR    = 8'h86;
  localparam logic [7:0] CMD_CLR_ROW    = 8'h87;
  localparam logic [7:0] CMD_ARM_SCREEN = 8'h88;
  localparam logic [7:0] CMD_ARM_LINE   = 8'h89;
  localparam logic [7:0] CMD_ROW        = 8'hA0;
  localparam logic [7:0] CMD_COL        = 8'hC0;

  localparam logic [7:0] CTRL_BYTES [13] = '{
    CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_LEFT, CH_RIGHT, CH_DOWN, CH_UP,
    CH_DEL, CH_NUL, CH_ESC
  };

  // Backspace at column 0, both color commands, delete and wrap in the last
  // column of the bottom row, save/restore, blink, clears and reset
  localparam logic [7:0] DIRECTED [26] = '{
    CH_NUL, 8'h41, CH_BS, CH_BS, CMD_ARM_LINE, 8'hEA, CMD_ARM_SCREEN | 8'h10, 8'h15,
    CH_LF, CH_VT, CMD_ROW | 8'd29, CMD_COL | 8'd63, CH_TAB, CH_TAB, CH_TAB, CH_TAB,
    CH_TAB, CH_DEL, 8'h7E, CMD_SAVE, CH_FF, CMD_RESTORE, CMD_BLINK_ON, CMD_CLR_ROW,
    CMD_CLR_SCR, CMD_RESET
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [3:0] op_o;
  logic [4:0] row_o;
  logic [6:0] col_o;
  logic [6:0] glyph_o;
  logic [2:0] color_o;
  logic       blink_on_o;
  logic [4:0] cursor_row_o;
  logic [6:0] cursor_col_o;
  logic       last_o;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_req      = 1'b0;
  bit          hold_taken    = 1'b0;

  text_terminal_command_parser_top #(
    .ROW_COUNT(ROW_COUNT)
  ) u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .out_valid_o,
    .out_ready_i,
    .op_o,
    .row_o,
    .col_o,
    .glyph_o,
    .color_o,
    .blink_on_o,
    .cursor_row_o,
    .cursor_col_o,
    .last_o
  );

  ttcp_draw_checker #(
    .ROW_COUNT(ROW_COUNT)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i    (in_ready_o),
    .in_byte_i,
    .out_valid_i   (out_valid_o),
    .out_ready_i,
    .op_i          (op_o),
    .row_i         (row_o),
    .col_i         (col_o),
    .glyph_i       (glyph_o),
    .color_i       (color_o),
    .blink_on_i    (blink_on_o),
    .cursor_row_i  (cursor_row_o),
    .cursor_col_i  (cursor_col_o),
    .last_i        (last_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off once requested
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("text_terminal_command_parser_top verification failed");
    $finish;
  end

  // Offer one byte, with random idle cycles first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Mostly text and control characters, commands and full color sequences
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(32, 126)));
    end else if (pick < 58) begin
      send_byte(CTRL_BYTES[$urandom_range(12)]);
    end else if (pick < 83) begin
      send_byte({1'b1, 7'($urandom)});
    end else if (pick < 93) begin
      send_byte(CMD_ARM_SCREEN | {3'b000, 1'($urandom), 3'b000, 1'($urandom)});
      send_byte(8'($urandom));
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slow receiver
    send_idle_pct = 23;
    recv_idle_pct = 88;
    foreach (DIRECTED[k]) send_byte(DIRECTED[k]);
    repeat (PHASE_ITEMS) send_random_item();

    // Slow sender
    send_idle_pct = 88;
    recv_idle_pct = 23;
    repeat (PHASE_ITEMS) send_random_item();

    // Full rate, opening with a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (PHASE_ITEMS) send_random_item();

    // Drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("text_terminal_command_parser_top verification clean");
    end else begin
      $display("text_terminal_command_parser_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ttcp_pkg.sv
rtl/ttcp_colors.sv
rtl/ttcp_decode.sv
rtl/ttcp_outbuf.sv
rtl/text_terminal_command_parser_top.sv
rtl/ttcp_checker.sv
dv/ttcp_draw_checker.sv
dv/tb.sv
